>>> rtl/srsa_pkg.sv
// shared constants and control types for the sweeping range scan assembler
`timescale 1ns / 1ps
`default_nettype none
package srsa_pkg;

  localparam int SENSORS = 4;
  localparam int STEPS = 9;
  localparam int SLOTS = SENSORS * STEPS;

  localparam int SENS_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int STEP_W = $clog2(STEPS);
  localparam int SLOT_W = 6;
  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int STEP_ANGLE_W = 15;
  localparam int CFG_W = 16;

  localparam logic CFG_START_ANGLE = 1'b0;
  localparam logic CFG_STEP_ANGLE = 1'b1;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'hFE3E;
  localparam logic [STEP_ANGLE_W-1:0] STEP_ANGLE_RST = 15'd100;

  typedef struct packed {
    logic capture;
    logic load_start;
    logic mem_wr;
    logic [SENS_W-1:0] sensor;
    logic advance;
    logic dump_rd;
    logic [SLOT_W-1:0] dump_idx;
    logic dump_first;
    logic dump_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic action;
    logic armed;
    logic scan_end;
  } dp_status_t;

endpackage
`default_nettype wire

>>> rtl/srsa_ctrl.sv
// controller: sequences start commands, buffer writes, angle update and scan dump
`timescale 1ns / 1ps
`default_nettype none
module srsa_ctrl
  import srsa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DUMP = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [SENS_W-1:0] sensor;
  logic [SENS_W-1:0] sensor_next;
  logic [SLOT_W-1:0] dump_idx;
  logic [SLOT_W-1:0] dump_idx_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    sensor_next = sensor;
    dump_idx_next = dump_idx;
    cmd = '0;
    cmd.sensor = sensor;
    cmd.dump_idx = dump_idx;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        sensor_next = '0;
        if (status.action == ACT_START) begin
          cmd.load_start = 1'b1;
          state_next = ST_IDLE;
        end else if (!status.armed) begin
          // ticks before the first start command are dropped
          state_next = ST_IDLE;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.mem_wr = 1'b1;
        sensor_next = sensor + 1'b1;
        if (sensor == SENS_W'(SENSORS - 1)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.advance = 1'b1;
        dump_idx_next = '0;
        state_next = status.scan_end ? ST_DUMP : ST_IDLE;
      end
      ST_DUMP: begin
        cmd.dump_rd = 1'b1;
        cmd.dump_first = (dump_idx == '0);
        cmd.dump_last = (dump_idx == SLOT_W'(SLOTS - 1));
        dump_idx_next = dump_idx + 1'b1;
        if (cmd.dump_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sensor <= '0;
      dump_idx <= '0;
    end else begin
      state <= state_next;
      sensor <= sensor_next;
      dump_idx <= dump_idx_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/srsa_datapath.sv
// datapath: config registers, joint angle, step state, scan buffer and result registers
`timescale 1ns / 1ps
`default_nettype none
module srsa_datapath
  import srsa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               action,
  input  wire logic [RANGE_W-1:0] range_0,
  input  wire logic [RANGE_W-1:0] range_1,
  input  wire logic [RANGE_W-1:0] range_2,
  input  wire logic [RANGE_W-1:0] range_3,
  input  wire ctrl_cmd_t          cmd,
  output dp_status_t              status,
  output logic                    strobe,
  output logic                    angle_valid,
  output logic [ANGLE_W-1:0]      target_angle,
  output logic                    scan_valid,
  output logic [SLOT_W-1:0]       slot_index,
  output logic [RANGE_W-1:0]      slot_range,
  output logic                    last
);

  logic [ANGLE_W-1:0] start_angle;
  logic [STEP_ANGLE_W-1:0] step_angle;
  logic [ANGLE_W-1:0] joint_angle;
  logic [ANGLE_W-1:0] joint_angle_next;
  logic [STEP_W-1:0] step_count;
  logic forward_dir;
  logic armed;
  logic item_action;
  logic [RANGE_W-1:0] in_ranges [4];
  logic [RANGE_W-1:0] item_range [SENSORS];
  logic [RANGE_W-1:0] scan_buffer [SLOTS];
  logic [SLOT_W:0] slot_base;
  logic [SLOT_W:0] slot_raw;
  logic [SLOT_W-1:0] wr_addr;
  logic scan_end;

  assign in_ranges[0] = range_0;
  assign in_ranges[1] = range_1;
  assign in_ranges[2] = range_2;
  assign in_ranges[3] = range_3;

  assign scan_end = (step_count == STEP_W'(STEPS - 1));
  assign status.action = item_action;
  assign status.armed = armed;
  assign status.scan_end = scan_end;

  // forward: sensor*STEPS + step, reverse: (sensor+1)*STEPS - step, buffer size wraps to 0
  always_comb begin
    slot_base = (SLOT_W+1)'(cmd.sensor) * (SLOT_W+1)'(STEPS);
    if (forward_dir) begin
      slot_raw = slot_base + (SLOT_W+1)'(step_count);
    end else begin
      slot_raw = slot_base + (SLOT_W+1)'(STEPS) - (SLOT_W+1)'(step_count);
    end
    if (slot_raw >= (SLOT_W+1)'(SLOTS)) begin
      wr_addr = '0;
    end else begin
      wr_addr = slot_raw[SLOT_W-1:0];
    end
  end

  assign joint_angle_next = forward_dir ? joint_angle + ANGLE_W'(step_angle)
                                        : joint_angle - ANGLE_W'(step_angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= START_ANGLE_RST;
      step_angle <= STEP_ANGLE_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_START_ANGLE) begin
        start_angle <= cfg_data;
      end else begin
        step_angle <= cfg_data[STEP_ANGLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_angle <= '0;
      step_count <= '0;
      forward_dir <= 1'b1;
      armed <= 1'b0;
    end else if (cmd.load_start) begin
      joint_angle <= start_angle;
      step_count <= '0;
      armed <= 1'b1;
    end else if (cmd.advance) begin
      joint_angle <= joint_angle_next;
      if (scan_end) begin
        step_count <= '0;
        forward_dir <= !forward_dir;
      end else begin
        step_count <= step_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_action <= action;
      for (int i = 0; i < SENSORS; i++) begin
        item_range[i] <= in_ranges[i];
      end
    end
  end

  // scan buffer: one write port, registered read straight into the result register
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      scan_buffer[wr_addr] <= item_range[cmd.sensor];
    end
    if (cmd.dump_rd) begin
      slot_range <= scan_buffer[cmd.dump_idx];
    end else if (cmd.load_start || cmd.advance) begin
      slot_range <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.load_start || (cmd.advance && !scan_end) || cmd.dump_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      angle_valid <= 1'b1;
      target_angle <= start_angle;
      scan_valid <= 1'b0;
      slot_index <= '0;
      last <= 1'b1;
    end else if (cmd.advance) begin
      angle_valid <= 1'b1;
      target_angle <= joint_angle_next;
      scan_valid <= 1'b0;
      slot_index <= '0;
      last <= 1'b1;
    end else if (cmd.dump_rd) begin
      // first entry of a dump also carries the new target
      angle_valid <= cmd.dump_first;
      target_angle <= cmd.dump_first ? joint_angle : '0;
      scan_valid <= 1'b1;
      slot_index <= cmd.dump_idx;
      last <= cmd.dump_last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sweeping_range_scan_assembler.sv
// top level of the sweeping range scan assembler
// start command: busy covers the decide state, and the result strobe is registered from the start-angle load
// ordinary tick: a decide state, one buffer write per sensor, an update state, then the registered result
// scan-end tick: the update gives no strobe, then a dump of all SLOTS entries, one buffer entry per cycle
// each result comes on a strobe; the receiver cannot stall
// synchronous reset: idle, disarmed, forward direction, angle and step count zero
`timescale 1ns / 1ps
`default_nettype none
module sweeping_range_scan_assembler
  import srsa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               action,
  input  wire logic [RANGE_W-1:0] range_0,
  input  wire logic [RANGE_W-1:0] range_1,
  input  wire logic [RANGE_W-1:0] range_2,
  input  wire logic [RANGE_W-1:0] range_3,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  output logic                    strobe,
  output logic                    angle_valid,
  output logic [ANGLE_W-1:0]      target_angle,
  output logic                    scan_valid,
  output logic [SLOT_W-1:0]       slot_index,
  output logic [RANGE_W-1:0]      slot_range,
  output logic                    last
);

  ctrl_cmd_t cmd;
  dp_status_t status;

  srsa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  srsa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .range_0      (range_0),
    .range_1      (range_1),
    .range_2      (range_2),
    .range_3      (range_3),
    .cmd          (cmd),
    .status       (status),
    .strobe       (strobe),
    .angle_valid  (angle_valid),
    .target_angle (target_angle),
    .scan_valid   (scan_valid),
    .slot_index   (slot_index),
    .slot_range   (slot_range),
    .last         (last)
  );

endmodule
`default_nettype wire

>>> verif/sweeping_range_scan_assembler_tb.sv
// self-checking testbench for the sweeping range scan assembler
`timescale 1ns / 1ps
module sweeping_range_scan_assembler_tb;
  import srsa_pkg::*;

  localparam int LIMIT = 400000;
  localparam int SETTLE = 60;

  typedef struct {
    logic                av;
    logic [ANGLE_W-1:0]  angle;
    logic                sv;
    logic [SLOT_W-1:0]   idx;
    logic [RANGE_W-1:0]  rng;
    logic                fin;
  } scan_result_t;

  class scan_scoreboard;
    logic [ANGLE_W-1:0]      start_reg;
    logic [STEP_ANGLE_W-1:0] step_reg;
    logic [RANGE_W-1:0]      scan_mem[SLOTS];
    int                      step_cnt;
    logic                    fwd;
    logic                    armed;
    logic [ANGLE_W-1:0]      joint;
    scan_result_t            pending_results[$];
    int                      errors;

    function new();
      start_reg = START_ANGLE_RST;
      step_reg = STEP_ANGLE_RST;
      foreach (scan_mem[i]) scan_mem[i] = '0;
      step_cnt = 0;
      fwd = 1'b1;
      armed = 1'b0;
      joint = '0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] data);
      if (idx == CFG_START_ANGLE) start_reg = data[ANGLE_W-1:0];
      else step_reg = data[STEP_ANGLE_W-1:0];
    endfunction

    function void push(logic av, logic [ANGLE_W-1:0] angle, logic sv, int idx,
                       logic [RANGE_W-1:0] rng, logic fin);
      scan_result_t r;
      r.av = av;
      r.angle = angle;
      r.sv = sv;
      r.idx = idx[SLOT_W-1:0];
      r.rng = rng;
      r.fin = fin;
      pending_results.push_back(r);
    endfunction

    // predicts the results of one accepted command transfer
    function void take_command(logic act, logic [3:0][RANGE_W-1:0] rd);
      int slot;
      if (act == ACT_START) begin
        joint = start_reg;
        step_cnt = 0;
        armed = 1'b1;
        push(1'b1, joint, 1'b0, 0, '0, 1'b1);
        return;
      end
      if (!armed) return;
      for (int i = 0; i < SENSORS; i++) begin
        slot = fwd ? i * STEPS + step_cnt : (i + 1) * STEPS - step_cnt;
        if (slot >= SLOTS) slot = 0;
        scan_mem[slot] = rd[i];
      end
      if (fwd) joint = joint + {1'b0, step_reg};
      else joint = joint - {1'b0, step_reg};
      step_cnt++;
      if (step_cnt < STEPS) begin
        push(1'b1, joint, 1'b0, 0, '0, 1'b1);
        return;
      end
      // scan end: whole buffer in slot order, target rides on the first entry
      for (int i = 0; i < SLOTS; i++)
        push(i == 0, (i == 0) ? joint : '0, 1'b1, i, scan_mem[i], i == SLOTS - 1);
      fwd = !fwd;
      step_cnt = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(scan_result_t got);
      scan_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result slot %0d range %h", got.idx, got.rng));
        return;
      end
      e = pending_results.pop_front();
      if (got.av !== e.av)
        report($sformatf("angle_valid %b, want %b", got.av, e.av));
      if (got.angle !== e.angle)
        report($sformatf("target_angle %h, want %h", got.angle, e.angle));
      if (got.sv !== e.sv)
        report($sformatf("scan_valid %b, want %b", got.sv, e.sv));
      if (got.idx !== e.idx)
        report($sformatf("slot_index %0d, want %0d", got.idx, e.idx));
      if (got.rng !== e.rng)
        report($sformatf("slot_range %h, want %h (slot %0d)", got.rng, e.rng, e.idx));
      if (got.fin !== e.fin)
        report($sformatf("last %b, want %b (slot %0d)", got.fin, e.fin, e.idx));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               action = ACT_TICK;
  logic [RANGE_W-1:0] range_0 = '0;
  logic [RANGE_W-1:0] range_1 = '0;
  logic [RANGE_W-1:0] range_2 = '0;
  logic [RANGE_W-1:0] range_3 = '0;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_START_ANGLE;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               strobe;
  logic               angle_valid;
  logic [ANGLE_W-1:0] target_angle;
  logic               scan_valid;
  logic [SLOT_W-1:0]  slot_index;
  logic [RANGE_W-1:0] slot_range;
  logic               last;

  scan_scoreboard sb = new();

  sweeping_range_scan_assembler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .range_0(range_0), .range_1(range_1), .range_2(range_2), .range_3(range_3),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .angle_valid(angle_valid), .target_angle(target_angle),
    .scan_valid(scan_valid), .slot_index(slot_index), .slot_range(slot_range),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    scan_result_t got;
    if (!rst && strobe === 1'b1) begin
      got.av = angle_valid;
      got.angle = target_angle;
      got.sv = scan_valid;
      got.idx = slot_index;
      got.rng = slot_range;
      got.fin = last;
      sb.check_result(got);
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return RANGE_W'($urandom);
    endcase
  endfunction

  // start is left high after the transfer; the next call or settle decides
  task automatic send(input logic act, input logic [3:0][RANGE_W-1:0] rd, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    action = act;
    range_0 = rd[0];
    range_1 = rd[1];
    range_2 = rd[2];
    range_3 = rd[3];
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.take_command(act, rd);
  endtask

  // drain all expected results, then allow for an ignored tick still in flight
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic tick_run(input int n, input int base);
    logic [3:0][RANGE_W-1:0] rd;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 4; i++)
        rd[i] = ((k + i) % 2) ? 16'hFFFF : RANGE_W'((base + k) * 4 + i);
      send(ACT_TICK, rd, 0);
    end
  endtask

  initial begin
    logic [3:0][RANGE_W-1:0] rd;
    logic [CFG_W-1:0]        sa;
    logic [CFG_W-1:0]        st;
    int                      idle;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed: wrap-around angles, ignored tick, both sweep directions, restart
    write_reg(CFG_START_ANGLE, 16'h7FFF);
    write_reg(CFG_STEP_ANGLE, 16'hFFFF);
    rd = '1;
    send(ACT_TICK, rd, 0);
    send(ACT_START, '0, 0);
    tick_run(STEPS, 0);
    send(ACT_START, '0, 0);
    tick_run(2, 20);
    send(ACT_START, '1, 0);
    // reverse sweep, top slot of the last sensor folds back to slot zero
    tick_run(STEPS, 40);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin sa = 16'h8000; st = 16'h0000; end
        1: begin sa = 16'h7FFF; st = 16'h7FFF; end
        2: begin sa = 16'h0000; st = 16'h8001; end
        5: begin sa = 16'hFE3E; st = 16'd100; end
        default: begin sa = CFG_W'($urandom); st = CFG_W'($urandom); end
      endcase
      write_reg(CFG_START_ANGLE, sa);
      write_reg(CFG_STEP_ANGLE, st);
      case (p % 3)
        0: idle = 0;
        1: idle = 60;
        default: idle = 35;
      endcase
      send(ACT_START, '0, idle);
      for (int n = 0; n < 82; n++) begin
        for (int i = 0; i < 4; i++) rd[i] = pick_range();
        // occasional restart breaks a sweep in the middle
        send(($urandom_range(99) < 8) ? ACT_START : ACT_TICK, rd, idle);
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
